/* src/lpht_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants of the linear-probe hash table: request codes,
// hash mixing constants, the hash unit status and the result layout.
// ----------------------------------------------------------------------------
package lpht_pkg;

    typedef enum logic [1:0] {
        ACT_QUERY  = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_WRITE  = 2'd2,
        ACT_CLEAR  = 2'd3
    } lpht_action_t;

    localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;
    localparam int          MIX_SHIFT_1 = 30;
    localparam int          MIX_SHIFT_2 = 27;
    localparam int          MIX_SHIFT_3 = 31;

    localparam int DATA_IN_BITS  = 80;
    localparam int DATA_OUT_BITS = 32;

    // hash unit status toward the controller
    typedef struct packed {
        logic        done;
        logic [63:0] value;
    } lpht_hash_t;

    // result layout, was_present in bit 0
    typedef struct packed {
        logic [9:0] count;
        logic       status;
        logic [9:0] slot;
        logic [7:0] value;
        logic       present;
    } lpht_result_t;

endpackage

/* src/linear_probe_hash_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash map, 64-bit keys, linear probing, splitmix64 hash.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_tvalid/s_tready/s_tdata (action, key, value); each
//   request gives exactly one result transaction on m_tvalid/m_tready/m_tdata.
//   The seed is to be written through cfg_we/cfg_wdata only while the block is
//   idle; the block itself does not enforce this. One request is worked on
//   at a time. A query, lookup or write first hashes the key, the hash running
//   its two 64-bit products on one 32x32 multiplier; the hash result issues
//   the first table read, and the probe then reads one slot per cycle until
//   it meets the key or a free slot.
//   A clear request rewrites every used flag, one slot per cycle, and gives
//   its result once that pass is through.
//   After reset the same pass runs over all TABLE_SLOTS slots while s_tready
//   stays low; seed writes are taken during it.
//   The result sits in an output register; the next request is taken while it
//   waits, and that request holds before its result until the receiver has
//   taken the previous one.
// ----------------------------------------------------------------------------
module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int TABLE_SLOTS = 1024,
    parameter int VALUE_BITS  = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [63:0]              cfg_wdata,   // hash_seed
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // action [1:0], search_key [65:2], write_value [73:66], zero pad above
    input  logic [DATA_IN_BITS-1:0]  s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // was_present [0], read_value [8:1], slot_index [18:9], status [19],
    // entry_count [29:20], zero pad above
    output logic [DATA_OUT_BITS-1:0] m_tdata
);

    localparam int SLOT_BITS = $clog2(TABLE_SLOTS);
    localparam int HALF      = TABLE_SLOTS / 2;
    localparam int CNT_W     = $clog2(HALF + 1);
    localparam int ROW_W     = 65 + VALUE_BITS;
    localparam int USED_BIT  = ROW_W - 1;
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(TABLE_SLOTS - 1);

    typedef enum logic [4:0] {
        ST_SWEEP = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_HASH  = 5'b00100,
        ST_PROBE = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [63:0]            seed_reg, seed_next;
    logic [SLOT_BITS-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   sweep_clear_reg, sweep_clear_next;
    logic                   m_tvalid_reg, m_tvalid_next;

    lpht_action_t           action_reg, action_next;
    logic [63:0]            key_reg, key_next;
    logic [7:0]             wv_reg, wv_next;
    lpht_result_t           res_reg, res_next;
    lpht_result_t           out_reg, out_next;

    logic [ROW_W-1:0]       table_mem [TABLE_SLOTS];
    logic [ROW_W-1:0]       rd_data_reg;
    logic                   rd_en;
    logic [SLOT_BITS-1:0]   rd_addr;
    logic                   wr_en;
    logic [SLOT_BITS-1:0]   wr_addr;
    logic [ROW_W-1:0]       wr_data;

    lpht_hash_t             hash_res;
    logic                   hash_start;
    logic                   accept;

    logic                   row_used;
    logic                   row_hit;
    logic [VALUE_BITS-1:0]  row_value;
    logic [VALUE_BITS-1:0]  wv_ext;
    logic [7:0]             wv_out;
    logic [7:0]             stored_out;
    logic [9:0]             slot_out;
    logic [9:0]             count_out;

    lpht_hash u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .key    (s_tdata[65:2]),
        .seed   (seed_reg),
        .result (hash_res)
    );

    assign row_used  = rd_data_reg[USED_BIT];
    assign row_value = rd_data_reg[USED_BIT-1:64];
    assign row_hit   = row_used && (rd_data_reg[63:0] == key_reg);

    // fit values, slot and count to their fixed result widths
    always_comb
    begin
        wv_ext     = '0;
        wv_out     = '0;
        stored_out = '0;
        slot_out   = '0;
        count_out  = '0;
        for (int b = 0; b < 8 && b < VALUE_BITS; b++)
        begin
            wv_ext[b]     = wv_reg[b];
            wv_out[b]     = wv_reg[b];
            stored_out[b] = row_value[b];
        end
        for (int b = 0; b < 10 && b < SLOT_BITS; b++)
        begin
            slot_out[b] = slot_reg[b];
        end
        for (int b = 0; b < 10 && b < CNT_W; b++)
        begin
            count_out[b] = count_reg[b];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next       = state_reg;
        seed_next        = seed_reg;
        slot_next        = slot_reg;
        count_next       = count_reg;
        sweep_clear_next = sweep_clear_reg;
        m_tvalid_next    = m_tvalid_reg;
        action_next      = action_reg;
        key_next         = key_reg;
        wv_next          = wv_reg;
        res_next         = res_reg;
        out_next         = out_reg;
        rd_en            = 1'b0;
        rd_addr          = slot_reg;
        wr_en            = 1'b0;
        wr_addr          = slot_reg;
        wr_data          = '0;
        hash_start       = 1'b0;

        if (cfg_we)
        begin
            seed_next = cfg_wdata;
        end
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_SWEEP:
            begin
                // drop the used flag of one slot per cycle
                wr_en     = 1'b1;
                slot_next = slot_reg + SLOT_BITS'(1);
                if (slot_reg == LAST_SLOT)
                begin
                    if (sweep_clear_reg)
                    begin
                        res_next         = '0;
                        sweep_clear_next = 1'b0;
                        state_next       = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    action_next = lpht_action_t'(s_tdata[1:0]);
                    key_next    = s_tdata[65:2];
                    wv_next     = s_tdata[73:66];
                    if (lpht_action_t'(s_tdata[1:0]) == ACT_CLEAR)
                    begin
                        sweep_clear_next = 1'b1;
                        slot_next        = '0;
                        count_next       = '0;
                        state_next       = ST_SWEEP;
                    end
                    else
                    begin
                        hash_start = 1'b1;
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH:
            begin
                if (hash_res.done)
                begin
                    slot_next  = hash_res.value[SLOT_BITS-1:0];
                    rd_en      = 1'b1;
                    rd_addr    = hash_res.value[SLOT_BITS-1:0];
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (!row_used || row_hit)
                begin
                    res_next      = '0;
                    res_next.slot = slot_out;
                    if (row_hit)
                    begin
                        res_next.present = 1'b1;
                        if (action_reg == ACT_WRITE)
                        begin
                            wr_en          = 1'b1;
                            wr_data        = {1'b1, wv_ext, key_reg};
                            res_next.value = wv_out;
                        end
                        else
                        begin
                            res_next.value = stored_out;
                        end
                    end
                    else if (action_reg != ACT_QUERY)
                    begin
                        if (count_reg >= CNT_W'(HALF))
                        begin
                            res_next.status = 1'b1;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            if (action_reg == ACT_WRITE)
                            begin
                                wr_data        = {1'b1, wv_ext, key_reg};
                                res_next.value = wv_out;
                            end
                            else
                            begin
                                wr_data = {1'b1, {VALUE_BITS{1'b0}}, key_reg};
                            end
                        end
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    // advance to the next slot, wrapping at the top
                    slot_next = slot_reg + SLOT_BITS'(1);
                    rd_en     = 1'b1;
                    rd_addr   = slot_reg + SLOT_BITS'(1);
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_next       = res_reg;
                    out_next.count = count_out;
                    m_tvalid_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_SWEEP;
            seed_reg        <= '0;
            slot_reg        <= '0;
            count_reg       <= '0;
            sweep_clear_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            seed_reg        <= seed_next;
            slot_reg        <= slot_next;
            count_reg       <= count_next;
            sweep_clear_reg <= sweep_clear_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        key_reg    <= key_next;
        wv_reg     <= wv_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    // table memory: one row per slot holding used flag, value and key
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(DATA_OUT_BITS - $bits(lpht_result_t)){1'b0}}, out_reg};

endmodule

/* src/lpht_hash.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_hash
// Seeded splitmix64 finalizer on one shared 32x32 multiplier. Each 64-bit
// product takes four phases: three partial products plus the final add.
// ----------------------------------------------------------------------------
module lpht_hash
    import lpht_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] key,
    input  logic [63:0] seed,
    output lpht_hash_t  result
);

    logic        busy_reg, busy_next;
    logic        round_reg, round_next;
    logic [1:0]  phase_reg, phase_next;
    logic        done_reg, done_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] pp_reg, pp_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] hash_reg, hash_next;

    logic [63:0] sum;
    logic [63:0] mul_const;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_p;
    logic [63:0] prod;

    assign sum       = key + seed;
    assign mul_const = round_reg ? MIX_MUL_B : MIX_MUL_A;
    assign mul_p     = {32'd0, mul_x} * {32'd0, mul_y};
    assign prod      = {acc_reg[63:32] + pp_reg[31:0], acc_reg[31:0]};

    always_comb
    begin
        case (phase_reg)
            2'd1:
            begin
                mul_x = a_reg[63:32];
                mul_y = mul_const[31:0];
            end
            2'd2:
            begin
                mul_x = a_reg[31:0];
                mul_y = mul_const[63:32];
            end
            default:
            begin
                mul_x = a_reg[31:0];
                mul_y = mul_const[31:0];
            end
        endcase
    end

    always_comb
    begin
        busy_next  = busy_reg;
        round_next = round_reg;
        phase_next = phase_reg;
        done_next  = 1'b0;
        a_next     = a_reg;
        pp_next    = pp_reg;
        acc_next   = acc_reg;
        hash_next  = hash_reg;
        if (start)
        begin
            a_next     = sum ^ (sum >> MIX_SHIFT_1);
            busy_next  = 1'b1;
            round_next = 1'b0;
            phase_next = 2'd0;
        end
        else if (busy_reg)
        begin
            phase_next = phase_reg + 2'd1;
            case (phase_reg)
                2'd0:
                begin
                    pp_next = mul_p;
                end
                2'd1:
                begin
                    acc_next = pp_reg;
                    pp_next  = mul_p;
                end
                2'd2:
                begin
                    acc_next[63:32] = acc_reg[63:32] + pp_reg[31:0];
                    pp_next         = mul_p;
                end
                default:
                begin
                    if (!round_reg)
                    begin
                        a_next     = prod ^ (prod >> MIX_SHIFT_2);
                        round_next = 1'b1;
                    end
                    else
                    begin
                        hash_next = prod ^ (prod >> MIX_SHIFT_3);
                        done_next = 1'b1;
                        busy_next = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            round_reg <= 1'b0;
            phase_reg <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            round_reg <= round_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        pp_reg   <= pp_next;
        acc_reg  <= acc_next;
        hash_reg <= hash_next;
    end

    assign result.done  = done_reg;
    assign result.value = hash_reg;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the linear-probe hash table. A scoreboard keeps its
// own copy of the table and the seed, predicts every result from the requests
// the block accepts, and compares each result transaction field by field.
// Stimulus runs directed corner cases, then random phases under several seeds
// and stall patterns, including a fill to half load and a seed change while full.
// ----------------------------------------------------------------------------
module tb
    import lpht_pkg::*;
();

    localparam int SLOTS       = 1024;
    localparam int MAX_KEYS    = SLOTS / 2;
    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    class hash_table_scoreboard;
        bit [63:0]    seed;
        bit [63:0]    keys [SLOTS];
        bit [7:0]     vals [SLOTS];
        bit           used [SLOTS];
        int unsigned  occupied;
        lpht_result_t expected_q [$];
        int           errors;
        int           requests;
        int           results;
        int           hits;
        int           refused;
        int           clears;

        function new();
            seed     = '0;
            occupied = 0;
            errors   = 0;
            requests = 0;
            results  = 0;
            hits     = 0;
            refused  = 0;
            clears   = 0;
            foreach (used[i]) used[i] = 1'b0;
        endfunction

        function void set_seed(input logic [63:0] s);
            seed = s;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [9:0] home_slot(input logic [63:0] k);
            logic [63:0] x;
            x = k + seed;
            x = (x ^ (x >> MIX_SHIFT_1)) * MIX_MUL_A;
            x = (x ^ (x >> MIX_SHIFT_2)) * MIX_MUL_B;
            x = x ^ (x >> MIX_SHIFT_3);
            return x[9:0];
        endfunction

        // walk up from the home slot to the key or the first free slot
        function logic [9:0] probe_slot(input logic [63:0] k);
            logic [9:0] i;
            i = home_slot(k);
            for (int n = 0; n < SLOTS; n++)
            begin
                if (!used[i] || keys[i] == k)
                    break;
                i = i + 10'd1;
            end
            return i;
        endfunction

        function void note_request(input logic [DATA_IN_BITS-1:0] d);
            lpht_action_t act;
            logic [63:0]  k;
            logic [7:0]   wv;
            logic [9:0]   slot;
            bit           hit;
            lpht_result_t res;
            act = lpht_action_t'(d[1:0]);
            k   = d[65:2];
            wv  = d[73:66];
            res = '0;
            requests++;
            if (act == ACT_CLEAR)
            begin
                foreach (used[i]) used[i] = 1'b0;
                occupied = 0;
                clears++;
            end
            else
            begin
                slot = probe_slot(k);
                hit  = used[slot] && keys[slot] == k;
                res.present = hit;
                res.slot    = slot;
                if (hit)
                begin
                    hits++;
                    if (act == ACT_WRITE)
                        vals[slot] = wv;
                    res.value = vals[slot];
                end
                else if (act != ACT_QUERY)
                begin
                    if (occupied >= MAX_KEYS || used[slot])
                    begin
                        res.status = 1'b1;
                        refused++;
                    end
                    else
                    begin
                        used[slot] = 1'b1;
                        keys[slot] = k;
                        vals[slot] = (act == ACT_WRITE) ? wv : 8'd0;
                        occupied++;
                        res.value = vals[slot];
                    end
                end
            end
            res.count = occupied[9:0];
            expected_q.insert(expected_q.size(), res);
        endfunction

        function void check_result(input logic [DATA_OUT_BITS-1:0] d);
            lpht_result_t got;
            lpht_result_t exp_res;
            got = d[$bits(lpht_result_t)-1:0];
            results++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, got %h", $time, got);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (got.present !== exp_res.present)
            begin
                $display("%0t: was_present expected %0d got %0d", $time, exp_res.present,
                         got.present);
                errors++;
            end
            if (got.value !== exp_res.value)
            begin
                $display("%0t: read_value expected %0h got %0h", $time, exp_res.value,
                         got.value);
                errors++;
            end
            if (got.slot !== exp_res.slot)
            begin
                $display("%0t: slot_index expected %0d got %0d", $time, exp_res.slot,
                         got.slot);
                errors++;
            end
            if (got.status !== exp_res.status)
            begin
                $display("%0t: status expected %0d got %0d", $time, exp_res.status,
                         got.status);
                errors++;
            end
            if (got.count !== exp_res.count)
            begin
                $display("%0t: entry_count expected %0d got %0d", $time, exp_res.count,
                         got.count);
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [63:0]              cfg_wdata;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [DATA_IN_BITS-1:0]  s_tdata;    // action, search_key, write_value, pad
    logic                     m_tvalid;
    logic                     m_tready;
    logic [DATA_OUT_BITS-1:0] m_tdata;    // was_present, read_value, slot_index,
                                          // status, entry_count, pad

    hash_table_scoreboard sb;
    logic [63:0] key_pool [$];
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off_armed;
    bit          hold_off_done;
    int          seed_writes;

    linear_probe_hash_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // track every transaction and seed write at the clock edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.set_seed(cfg_wdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (s_tvalid && s_tready)
                sb.note_request(s_tdata);
        end
    end

    // result side: random stalls plus one long hold-off to back up the input
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_armed && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, quiet);
                $display("linear_probe_hash_table regression: fail");
                $finish;
            end
        end
    end

    task automatic send_request(input lpht_action_t act, input logic [63:0] key,
                                input logic [7:0] wv);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, wv, key, act};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic sender_stop();
        s_tvalid <= 1'b0;
    endtask

    // wait for every expected result to come back
    task automatic drain();
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_seed(input logic [63:0] s);
        cfg_wdata <= s;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        seed_writes++;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    function automatic logic [63:0] pick_key(input int pool_pct);
        logic [63:0] k;
        if (key_pool.size() != 0 && $urandom_range(99) < pool_pct)
            k = key_pool[$urandom_range(key_pool.size() - 1)];
        else
        begin
            k = {$urandom, $urandom};
            if ($urandom_range(24) == 0)
                k = $urandom_range(1) ? 64'hffff_ffff_ffff_ffff : 64'd0;
            key_pool.insert(key_pool.size(), k);
            if (key_pool.size() > 700)
                void'(key_pool.pop_front());
        end
        return k;
    endfunction

    task automatic send_mixed(input int pool_pct, input bit allow_clear);
        int           r;
        lpht_action_t act;
        r = $urandom_range(99);
        if (allow_clear && r < 2)
            act = ACT_CLEAR;
        else if (r < 27)
            act = ACT_QUERY;
        else if (r < 52)
            act = ACT_LOOKUP;
        else
            act = ACT_WRITE;
        send_request(act, pick_key(pool_pct), 8'($urandom_range(255)));
    endtask

    task automatic random_phase(input logic [63:0] s, input int n_items,
                                input int send_pct, input int recv_pct);
        sender_stop();
        drain();
        write_seed(s);
        set_idling(send_pct, recv_pct);
        for (int n = 0; n < n_items; n++)
            send_mixed(60, 1'b1);
    endtask

    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_armed = 1'b0;
        hold_off_done  = 1'b0;
        seed_writes    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        write_seed(64'd0);

        // directed corners, seed zero, no idling
        send_request(ACT_QUERY,  64'd0, 8'h00);
        send_request(ACT_LOOKUP, 64'd0, 8'hff);
        send_request(ACT_QUERY,  64'd0, 8'h3c);
        send_request(ACT_WRITE,  64'hffff_ffff_ffff_ffff, 8'hff);
        send_request(ACT_WRITE,  64'hffff_ffff_ffff_ffff, 8'h00);
        send_request(ACT_WRITE,  64'hffff_ffff_ffff_ffff, 8'ha5);
        send_request(ACT_LOOKUP, 64'hffff_ffff_ffff_ffff, 8'h5a);
        send_request(ACT_WRITE,  64'd0, 8'hff);
        send_request(ACT_QUERY,  64'd0, 8'h00);
        send_request(ACT_QUERY,  64'h8000_0000_0000_0000, 8'hff);
        send_request(ACT_WRITE,  64'h0123_4567_89ab_cdef, 8'h5a);
        send_request(ACT_LOOKUP, 64'h5555_5555_5555_5555, 8'haa);
        send_request(ACT_QUERY,  64'h0123_4567_89ab_cdef, 8'h01);
        send_request(ACT_CLEAR,  64'hdead_beef_0bad_f00d, 8'h77);
        send_request(ACT_QUERY,  64'hffff_ffff_ffff_ffff, 8'h00);
        send_request(ACT_LOOKUP, 64'hffff_ffff_ffff_ffff, 8'h00);
        send_request(ACT_QUERY,  64'd0, 8'h00);
        send_request(ACT_WRITE,  64'd1, 8'h80);

        random_phase(64'hffff_ffff_ffff_ffff, 150, 0, 0);
        random_phase({$urandom, $urandom}, 120, 84, 0);
        random_phase({$urandom, $urandom}, 120, 0, 84);
        random_phase({$urandom, $urandom}, 120, 29, 29);

        // fill to half load while the result side holds off at first
        sender_stop();
        drain();
        write_seed({$urandom, $urandom});
        set_idling(0, 0);
        key_pool.delete();
        send_request(ACT_CLEAR, 64'd0, 8'd0);
        sender_stop();
        drain();
        hold_off_armed = 1'b1;
        for (int n = 0; n < MAX_KEYS + 10; n++)
            send_request($urandom_range(9) < 7 ? ACT_WRITE : ACT_LOOKUP, pick_key(0),
                         8'($urandom_range(255)));
        // at half load: new keys are refused, present keys still update
        for (int n = 0; n < 40; n++)
            send_mixed(50, 1'b0);

        // change the seed with the table full; stored keys may go missing
        sender_stop();
        drain();
        write_seed({$urandom, $urandom});
        set_idling(29, 29);
        for (int n = 0; n < 50; n++)
            send_mixed(80, 1'b0);
        send_request(ACT_CLEAR, pick_key(100), 8'($urandom_range(255)));

        sender_stop();
        drain();
        repeat (64) @(posedge clk);
        $display("covered %0d requests under %0d seed settings: %0d hits, %0d refused inserts,",
                 sb.requests, seed_writes, sb.hits, sb.refused);
        $display("%0d clears, %0d results checked, %0d mismatches",
                 sb.clears, sb.results, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("linear_probe_hash_table regression: pass");
        else
            $display("linear_probe_hash_table regression: fail");
        $finish;
    end

endmodule
